// ===== hdl/pup_pkg.sv =====
package pup_pkg;

    localparam int SPRITE_DEPTH  = 256;
    localparam int SPRITE_AW     = $clog2(SPRITE_DEPTH);
    localparam int PALETTE_DEPTH = 32;
    localparam int PALETTE_AW    = $clog2(PALETTE_DEPTH);
    localparam int VSPACE_AW     = 14;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OADDR  = 3'd3;
    localparam logic [2:0] REG_ODATA  = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_VADDR  = 3'd6;
    localparam logic [2:0] REG_VDATA  = 3'd7;

    localparam logic [15:0] BULK_LOAD_ADDR = 16'h4014;
    localparam logic [5:0]  PALETTE_PAGE   = 6'h3F;
    localparam logic [15:0] STEP_FAR       = 16'd32;
    localparam logic [15:0] STEP_NEAR      = 16'd1;
    localparam int          CTRL_STEP_BIT  = 2;
    localparam int          STATUS_VBL_BIT = 2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] register_address;
        logic [7:0]  write_data;
        logic [7:0]  sprite_load_index;
        logic [2:0]  status_bits;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  control_value;
        logic [7:0]  mask_value;
        logic [7:0]  scroll_x;
        logic [7:0]  scroll_y;
        logic [15:0] video_address;
    } t_out_item;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [SPRITE_AW-1:0] addr;
        logic [7:0]           wdata;
    } t_oam_req;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [VSPACE_AW-1:0] addr;
        logic [7:0]           wdata;
    } t_vram_req;

endpackage

// ===== hdl/pup_oam.sv =====
module pup_oam
    import pup_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_oam_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0]              mem [SPRITE_DEPTH];
    logic [SPRITE_DEPTH-1:0] r_valid;
    logic [7:0]              r_rdata;
    logic                    r_rd_valid;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata    <= mem[i_req.addr];
            r_rd_valid <= r_valid[i_req.addr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : 8'h00;

endmodule

// ===== hdl/pup_vram.sv =====
module pup_vram
    import pup_pkg::*;
#(
    parameter int VIDEO_DEPTH = 16384
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_vram_req  i_req,
    output logic [7:0] o_rdata
);

    localparam int VW = $clog2(VIDEO_DEPTH);

    logic [7:0] mem [VIDEO_DEPTH];
    logic [7:0] r_pal [PALETTE_DEPTH];
    logic [7:0] r_mem_rd;
    logic [7:0] r_pal_rd;
    logic       r_sel_pal;
    logic       is_pal;
    logic [VW-1:0]         mem_idx;
    logic [PALETTE_AW-1:0] pal_idx;

    assign is_pal  = (i_req.addr[VSPACE_AW-1:8] == PALETTE_PAGE);
    assign mem_idx = i_req.addr[VW-1:0];
    assign pal_idx = i_req.addr[PALETTE_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PALETTE_DEPTH; k++) begin
                r_pal[k] <= 8'h00;
            end
        end else if (i_req.we && is_pal) begin
            r_pal[pal_idx] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we && !is_pal) begin
            mem[mem_idx] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_mem_rd  <= mem[mem_idx];
            r_pal_rd  <= r_pal[pal_idx];
            r_sel_pal <= is_pal;
        end
    end

    assign o_rdata = r_sel_pal ? r_pal_rd : r_mem_rd;

endmodule

// ===== hdl/picture_unit_register_port_unit.sv =====
// CPU-facing register port of a video picture unit.
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one bus read,
// bus write or sprite table load byte per item. Output channel
// (o_out_valid / i_out_ready / o_out_item) returns exactly one item per
// input item, in order: the byte read (or the bus latch) and the control,
// mask, scroll and video address registers as they stand after that item.
// An accepted item passes through stage one and then the output register.
// Throughput is one item per cycle: register and address updates happen
// at acceptance, the sprite and video memories are read in that same cycle
// with registered data, and the bus latch is resolved one stage later from
// that data. When the receiver stalls, the output register and the stage
// behind it fill and o_in_ready drops after two items; nothing is lost or
// repeated.
// Synchronous active-low reset clears the user registers, toggles, latch, valid
// flags, palette and sprite table valid bits, so the sprite table reads zero until written.
// The video memory has no reset and must be written before it is read.
module picture_unit_register_port_unit
    import pup_pkg::*;
#(
    parameter int VIDEO_DEPTH = 16384
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {
        LAT_KEEP,
        LAT_DATA,
        LAT_STATUS,
        LAT_SPRITE,
        LAT_VIDEO
    } t_lat;

    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_sx, n_sx;
    logic [7:0]  r_sy, n_sy;
    logic [15:0] r_oaddr, n_oaddr;
    logic [15:0] r_vaddr, n_vaddr;
    logic        r_otgl, n_otgl;
    logic        r_stgl, n_stgl;
    logic        r_vtgl, n_vtgl;
    logic [7:0]  r_latch, n_latch;

    logic        r_s1_valid;
    t_lat        r_s1_lat, n_lat;
    t_out_item   r_s1_item;

    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        in_fire, s1_move;
    logic [2:0]  sel;
    logic        is_rd, is_wr;
    logic [15:0] vstep;
    logic [7:0]  oam_rd, vram_rd;
    t_oam_req    oam_req;
    t_vram_req   vram_req;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_fire    = i_in_valid && o_in_ready;

    assign sel   = i_in_item.register_address[2:0];
    assign is_rd = (i_in_item.operation == OP_READ);
    assign is_wr = (i_in_item.operation == OP_WRITE)
                   && (i_in_item.register_address != BULK_LOAD_ADDR);
    assign vstep = r_ctrl[CTRL_STEP_BIT] ? STEP_FAR : STEP_NEAR;

    always_comb begin
        n_ctrl  = r_ctrl;
        n_mask  = r_mask;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_oaddr = r_oaddr;
        n_vaddr = r_vaddr;
        n_otgl  = r_otgl;
        n_stgl  = r_stgl;
        n_vtgl  = r_vtgl;
        n_lat   = LAT_KEEP;
        if (i_in_item.operation == OP_WRITE) begin
            n_lat = LAT_DATA;
        end
        if (is_rd) begin
            unique case (sel)
                REG_STATUS: begin
                    n_stgl = 1'b0;
                    n_vtgl = 1'b0;
                    n_lat  = LAT_STATUS;
                end
                REG_ODATA: begin
                    n_lat = LAT_SPRITE;
                end
                REG_VDATA: begin
                    n_vaddr = r_vaddr + vstep;
                    n_lat   = LAT_VIDEO;
                end
                default: begin
                    n_lat = LAT_KEEP;
                end
            endcase
        end else if (is_wr) begin
            unique case (sel)
                REG_CTRL: n_ctrl = i_in_item.write_data;
                REG_MASK: n_mask = i_in_item.write_data;
                REG_OADDR: begin
                    if (r_otgl) begin
                        n_oaddr = {r_oaddr[15:8], i_in_item.write_data};
                    end else begin
                        n_oaddr = {i_in_item.write_data, r_oaddr[7:0]};
                    end
                    n_otgl = !r_otgl;
                end
                REG_ODATA: begin
                    if (!i_in_item.status_bits[STATUS_VBL_BIT]) begin
                        n_oaddr = r_oaddr + 16'd1;
                    end
                end
                REG_SCROLL: begin
                    if (r_stgl) begin
                        n_sy = i_in_item.write_data;
                    end else begin
                        n_sx = i_in_item.write_data;
                    end
                    n_stgl = !r_stgl;
                end
                REG_VADDR: begin
                    if (r_vtgl) begin
                        n_vaddr = {r_vaddr[15:8], i_in_item.write_data};
                    end else begin
                        n_vaddr = {i_in_item.write_data, r_vaddr[7:0]};
                    end
                    n_vtgl = !r_vtgl;
                end
                REG_VDATA: n_vaddr = r_vaddr + vstep;
                default: n_ctrl = r_ctrl;
            endcase
        end
    end

    always_comb begin
        oam_req.we    = in_fire && ((is_wr && sel == REG_ODATA)
                                    || i_in_item.operation == OP_LOAD);
        oam_req.re    = in_fire && is_rd && sel == REG_ODATA;
        oam_req.addr  = (i_in_item.operation == OP_LOAD) ? i_in_item.sprite_load_index
                                                          : r_oaddr[SPRITE_AW-1:0];
        oam_req.wdata = i_in_item.write_data;
        vram_req.we    = in_fire && is_wr && sel == REG_VDATA;
        vram_req.re    = in_fire && is_rd && sel == REG_VDATA;
        vram_req.addr  = r_vaddr[VSPACE_AW-1:0];
        vram_req.wdata = i_in_item.write_data;
    end

    pup_oam u_oam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (oam_req),
        .o_rdata (oam_rd)
    );

    pup_vram #(
        .VIDEO_DEPTH (VIDEO_DEPTH)
    ) u_vram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (vram_req),
        .o_rdata (vram_rd)
    );

    always_comb begin
        unique case (r_s1_lat)
            LAT_DATA:   n_latch = r_s1_item.read_data;
            LAT_STATUS: n_latch = {r_s1_item.read_data[2:0], r_latch[4:0]};
            LAT_SPRITE: n_latch = oam_rd;
            LAT_VIDEO:  n_latch = vram_rd;
            default:    n_latch = r_latch;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= '0;
            r_mask      <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_oaddr     <= '0;
            r_vaddr     <= '0;
            r_otgl      <= 1'b0;
            r_stgl      <= 1'b0;
            r_vtgl      <= 1'b0;
            r_latch     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_ctrl  <= n_ctrl;
                r_mask  <= n_mask;
                r_sx    <= n_sx;
                r_sy    <= n_sy;
                r_oaddr <= n_oaddr;
                r_vaddr <= n_vaddr;
                r_otgl  <= n_otgl;
                r_stgl  <= n_stgl;
                r_vtgl  <= n_vtgl;
            end
            if (s1_move) begin
                r_latch <= n_latch;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage one read_data carries the written byte or the status flags
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_lat                <= n_lat;
            r_s1_item.read_data     <= (n_lat == LAT_STATUS)
                                       ? {5'd0, i_in_item.status_bits}
                                       : i_in_item.write_data;
            r_s1_item.control_value <= n_ctrl;
            r_s1_item.mask_value    <= n_mask;
            r_s1_item.scroll_x      <= n_sx;
            r_s1_item.scroll_y      <= n_sy;
            r_s1_item.video_address <= n_vaddr;
        end
        if (s1_move) begin
            r_out_item.read_data     <= n_latch;
            r_out_item.control_value <= r_s1_item.control_value;
            r_out_item.mask_value    <= r_s1_item.mask_value;
            r_out_item.scroll_x      <= r_s1_item.scroll_x;
            r_out_item.scroll_y      <= r_s1_item.scroll_y;
            r_out_item.video_address <= r_s1_item.video_address;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |=> (r_s1_valid && $stable(r_latch)))
        else $error("stage one dropped while output stalled");

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_rd && sel == REG_STATUS) |=> (!r_stgl && !r_vtgl))
        else $error("status read did not clear toggles");

    a_vstep_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_rd && sel == REG_VDATA && r_ctrl[CTRL_STEP_BIT])
        |=> (r_vaddr == $past(r_vaddr) + STEP_FAR))
        else $error("video address step wrong");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_item.operation == OP_LOAD)
        |=> ($stable(r_ctrl) && $stable(r_vaddr) && $stable(r_oaddr)))
        else $error("load item changed registers");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("output lost an item");

endmodule

// ===== tb/sv/tb_picture_unit_register_port_unit.sv =====
`timescale 1ns / 100ps

module tb_picture_unit_register_port_unit
    import pup_pkg::*;
();

    localparam int         VRAM_DEPTH     = 16384;
    localparam int         QUIET_LIMIT    = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         RX_HOLD_CYCLES = 200;
    localparam logic [1:0] OP_IDLE        = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    // register view the renderer should see, tracked item by item
    logic [7:0]  pv_latch;
    logic [7:0]  pv_ctrl;
    logic [7:0]  pv_mask;
    logic [7:0]  pv_scroll_x;
    logic [7:0]  pv_scroll_y;
    logic [15:0] pv_oam_addr;
    logic [15:0] pv_vram_addr;
    logic        pv_oam_tog;
    logic        pv_scroll_tog;
    logic        pv_vram_tog;
    logic [7:0]  oam_copy   [SPRITE_DEPTH];
    logic [7:0]  pal_copy   [PALETTE_DEPTH];
    logic [7:0]  vram_copy  [VRAM_DEPTH];
    bit          vram_known [VRAM_DEPTH];

    t_out_item   pending_views[$];
    int unsigned items_sent   = 0;
    int unsigned bad_count    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left    = 0;
    bit          no_gaps      = 1'b0;

    always #10 clk = ~clk;

    picture_unit_register_port_unit #(
        .VIDEO_DEPTH(VRAM_DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    function automatic logic [15:0] vram_step();
        return pv_ctrl[CTRL_STEP_BIT] ? STEP_FAR : STEP_NEAR;
    endfunction

    function automatic bit vram_readable(input logic [15:0] addr);
        return addr[13:8] == PALETTE_PAGE || vram_known[addr[13:0] % VRAM_DEPTH];
    endfunction

    function automatic t_out_item apply_bus_item(input t_in_item it);
        logic [2:0]  sel;
        logic [7:0]  d;
        logic [15:0] va;
        t_out_item   view;
        sel = it.register_address[2:0];
        d   = it.write_data;
        va  = pv_vram_addr;
        case (it.operation)
            OP_READ: begin
                case (sel)
                    REG_STATUS: begin
                        pv_scroll_tog = 1'b0;
                        pv_vram_tog   = 1'b0;
                        pv_latch      = {it.status_bits, pv_latch[4:0]};
                    end
                    REG_ODATA: pv_latch = oam_copy[pv_oam_addr[7:0]];
                    REG_VDATA: begin
                        if (va[13:8] == PALETTE_PAGE) pv_latch = pal_copy[va[4:0]];
                        else pv_latch = vram_copy[va[13:0] % VRAM_DEPTH];
                        pv_vram_addr = va + vram_step();
                    end
                    default: ;
                endcase
            end
            OP_WRITE: begin
                pv_latch = d;
                if (it.register_address != BULK_LOAD_ADDR) begin
                    case (sel)
                        REG_CTRL: pv_ctrl = d;
                        REG_MASK: pv_mask = d;
                        REG_OADDR: begin
                            if (pv_oam_tog) pv_oam_addr[7:0] = d;
                            else pv_oam_addr[15:8] = d;
                            pv_oam_tog = !pv_oam_tog;
                        end
                        REG_ODATA: begin
                            oam_copy[pv_oam_addr[7:0]] = d;
                            if (!it.status_bits[STATUS_VBL_BIT]) pv_oam_addr = pv_oam_addr + 16'd1;
                        end
                        REG_SCROLL: begin
                            if (pv_scroll_tog) pv_scroll_y = d;
                            else pv_scroll_x = d;
                            pv_scroll_tog = !pv_scroll_tog;
                        end
                        REG_VADDR: begin
                            if (pv_vram_tog) pv_vram_addr[7:0] = d;
                            else pv_vram_addr[15:8] = d;
                            pv_vram_tog = !pv_vram_tog;
                        end
                        REG_VDATA: begin
                            if (va[13:8] == PALETTE_PAGE) begin
                                pal_copy[va[4:0]] = d;
                            end else begin
                                vram_copy[va[13:0] % VRAM_DEPTH]  = d;
                                vram_known[va[13:0] % VRAM_DEPTH] = 1'b1;
                            end
                            pv_vram_addr = va + vram_step();
                        end
                        default: ;
                    endcase
                end
            end
            OP_LOAD: oam_copy[it.sprite_load_index] = d;
            default: ;
        endcase
        view.read_data     = pv_latch;
        view.control_value = pv_ctrl;
        view.mask_value    = pv_mask;
        view.scroll_x      = pv_scroll_x;
        view.scroll_y      = pv_scroll_y;
        view.video_address = pv_vram_addr;
        return view;
    endfunction

    function automatic t_in_item mk(input logic [1:0] op, input logic [15:0] addr,
                                    input logic [7:0] d, input logic [7:0] ix,
                                    input logic [2:0] st);
        return {op, addr, d, ix, st};
    endfunction

    function automatic t_in_item reg_item(input logic [1:0] op, input logic [2:0] sel,
                                          input logic [7:0] d);
        return mk(op, {13'($urandom), sel}, d, 8'($urandom), 3'($urandom));
    endfunction

    task automatic issue_item(input t_in_item it);
        int unsigned idle;
        t_in_item    item;
        item = it;
        // never read video memory that has not been written
        if (item.operation == OP_READ && item.register_address[2:0] == REG_VDATA
            && !vram_readable(pv_vram_addr)) item.operation = OP_WRITE;
        idle = 0;
        if (!no_gaps) while ($urandom_range(99) < 25) idle++;
        if (idle != 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        pending_views.push_back(apply_bus_item(item));
        items_sent++;
    endtask

    task automatic video_roundtrip(input bit to_palette);
        logic [15:0] a;
        int unsigned n;
        n = $urandom_range(1, 6);
        a = 16'($urandom);
        if (to_palette) a[13:8] = PALETTE_PAGE;
        issue_item(reg_item(OP_WRITE, REG_CTRL, 8'($urandom)));
        for (int pass = 0; pass < 2; pass++) begin
            issue_item(reg_item(OP_READ, REG_STATUS, 8'($urandom)));
            issue_item(reg_item(OP_WRITE, REG_VADDR, a[15:8]));
            issue_item(reg_item(OP_WRITE, REG_VADDR, a[7:0]));
            repeat (n) issue_item(reg_item(pass == 0 ? OP_WRITE : OP_READ, REG_VDATA,
                                           8'($urandom)));
        end
    endtask

    task automatic sprite_walk();
        logic [15:0] a;
        int unsigned n;
        n = $urandom_range(1, 6);
        a = 16'($urandom);
        if (pv_oam_tog) issue_item(reg_item(OP_WRITE, REG_OADDR, 8'($urandom)));
        issue_item(reg_item(OP_WRITE, REG_OADDR, a[15:8]));
        issue_item(reg_item(OP_WRITE, REG_OADDR, a[7:0]));
        repeat (n) begin
            issue_item(reg_item(OP_READ, REG_ODATA, 8'($urandom)));
            issue_item(reg_item(OP_WRITE, REG_ODATA, 8'($urandom)));
        end
    endtask

    task automatic scroll_setup();
        issue_item(reg_item(OP_READ, REG_STATUS, 8'($urandom)));
        issue_item(reg_item(OP_WRITE, REG_SCROLL, 8'($urandom)));
        issue_item(reg_item(OP_WRITE, REG_SCROLL, 8'($urandom)));
        issue_item(reg_item(OP_WRITE, REG_CTRL, 8'($urandom)));
        issue_item(reg_item(OP_WRITE, REG_MASK, 8'($urandom)));
    endtask

    task automatic sprite_bulk_load();
        issue_item(mk(OP_WRITE, BULK_LOAD_ADDR, 8'($urandom), 8'($urandom), 3'($urandom)));
        repeat ($urandom_range(4, 8))
            issue_item(mk(OP_LOAD, 16'($urandom), 8'($urandom), 8'($urandom), 3'($urandom)));
    endtask

    task automatic run_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                video_roundtrip($urandom_range(3) == 0);
            end else if (pick < 48) begin
                sprite_walk();
            end else if (pick < 58) begin
                scroll_setup();
            end else if (pick < 66) begin
                sprite_bulk_load();
            end else begin
                repeat ($urandom_range(1, 4))
                    issue_item(mk(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                                  3'($urandom)));
            end
        end
    endtask

    task automatic test_edge_values();
        issue_item(mk(OP_READ,  16'h2002, 8'h00, 8'h00, 3'b111));
        issue_item(mk(OP_WRITE, 16'h2000, 8'hFF, 8'hFF, 3'b000));
        issue_item(mk(OP_WRITE, 16'hFFF8, 8'h00, 8'h00, 3'b111));
        issue_item(mk(OP_WRITE, 16'h2001, 8'hFF, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2002, 8'h55, 8'h00, 3'b000));
        issue_item(mk(OP_READ,  16'h3FFA, 8'h00, 8'h00, 3'b000));
        // bulk load address: latch only, no sprite data write
        issue_item(mk(OP_WRITE, BULK_LOAD_ADDR, 8'hAA, 8'h00, 3'b000));
        issue_item(mk(OP_LOAD,  16'h0000, 8'hFF, 8'h00, 3'b000));
        issue_item(mk(OP_LOAD,  16'hFFFF, 8'h5A, 8'hFF, 3'b111));
        issue_item(mk(OP_WRITE, 16'h2003, 8'hFF, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2003, 8'hFF, 8'h00, 3'b000));
        issue_item(mk(OP_READ,  16'h2004, 8'h00, 8'h00, 3'b000));
        // vertical blank holds the sprite address, then it wraps to zero
        issue_item(mk(OP_WRITE, 16'h2004, 8'h11, 8'h00, 3'b100));
        issue_item(mk(OP_WRITE, 16'h2004, 8'h22, 8'h00, 3'b011));
        issue_item(mk(OP_READ,  16'h2004, 8'h00, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2005, 8'hFF, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2005, 8'h00, 8'h00, 3'b000));
        // video address wraps after the top palette entry
        issue_item(mk(OP_WRITE, 16'h2006, 8'hFF, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2006, 8'hFF, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2007, 8'h3C, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2006, 8'h3F, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2006, 8'h1F, 8'h00, 3'b000));
        issue_item(mk(OP_READ,  16'h2007, 8'h00, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2000, 8'h04, 8'h00, 3'b000));
        issue_item(mk(OP_WRITE, 16'h2007, 8'h81, 8'h00, 3'b000));
        issue_item(mk(OP_IDLE,  16'hFFFF, 8'hFF, 8'hFF, 3'b111));
    endtask

    task automatic test_mixed_traffic();
        run_traffic(550);
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        run_traffic(150);
        no_gaps = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_left = RX_HOLD_CYCLES;
        run_traffic(40);
    endtask

    task automatic test_drain_pause();
        run_traffic(40);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_views.size() != 0);
        run_traffic(200);
    endtask

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        pv_latch      = '0;
        pv_ctrl       = '0;
        pv_mask       = '0;
        pv_scroll_x   = '0;
        pv_scroll_y   = '0;
        pv_oam_addr   = '0;
        pv_vram_addr  = '0;
        pv_oam_tog    = 1'b0;
        pv_scroll_tog = 1'b0;
        pv_vram_tog   = 1'b0;
        for (int k = 0; k < SPRITE_DEPTH; k++) oam_copy[k] = '0;
        for (int k = 0; k < PALETTE_DEPTH; k++) pal_copy[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_values();
        test_mixed_traffic();
        test_back_to_back();
        test_output_hold();
        test_drain_pause();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_views.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_count == 0) begin
            $display("picture_unit_register_port_unit verification clean");
        end else begin
            $display("picture_unit_register_port_unit verification failed");
        end
        $finish;
    end

    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= no_gaps || $urandom_range(99) >= 25;
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("picture_unit_register_port_unit verification failed");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (pending_views.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unrequested item: rd %02h ctrl %02h va %04h",
                                 out_item.read_data, out_item.control_value,
                                 out_item.video_address);
                end else begin
                    want = pending_views.pop_front();
                    if (out_item !== want) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("mismatch want/got: rd %02h/%02h ctrl %02h/%02h mask %02h/%02h",
                                     want.read_data, out_item.read_data,
                                     want.control_value, out_item.control_value,
                                     want.mask_value, out_item.mask_value);
                            $display("  sx %02h/%02h sy %02h/%02h va %04h/%04h",
                                     want.scroll_x, out_item.scroll_x,
                                     want.scroll_y, out_item.scroll_y,
                                     want.video_address, out_item.video_address);
                        end
                    end
                end
            end
        end
    end

endmodule
